[rtl/core/tbrl_pkg.sv]
// Shared widths, reset values, codes and types of the token bucket rate limiter.
package tbrl_pkg;

    localparam int NOW_W    = 32;   // request timestamp
    localparam int NEED_W   = 16;   // packet length
    localparam int WAIT_W   = 26;   // wait time in us
    localparam int TOKOUT_W = 32;   // reported token count
    localparam int RATE_W   = 20;   // fill rate register
    localparam int CAP_W    = 32;   // capacity register
    localparam int DATA_W   = 32;   // config data bus
    localparam int ADDR_W   = 3;    // config byte address
    localparam int NUM_W    = 26;   // 1000 * deficit
    localparam int CNT_W    = $clog2(NUM_W + 1);

    localparam int TOKEN_BITS_DEF = 32;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [RATE_W-1:0] FILL_RATE_RST = 20'd1250;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 32'd1250000;
    localparam logic [WAIT_W-1:0] WAIT_MAX      = {WAIT_W{1'b1}};
    localparam logic [9:0]        US_PER_MS     = 10'd1000;

    // register select bit, paddr[2]
    localparam logic REG_FILL_RATE = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFILL,
        ST_MUL,
        ST_UPDATE,
        ST_SETTLE,
        ST_DIV,
        ST_DONE
    } tbrl_state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } tbrl_op_t;

    typedef struct packed {
        logic     start;
        tbrl_op_t op;
    } tbrl_cmd_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } tbrl_sts_t;

endpackage

[rtl/core/tbrl_if.sv]
// Request and response channel interfaces of the token bucket rate limiter.
interface tbrl_req_if;
    import tbrl_pkg::*;

    logic              valid;
    logic              ready;
    logic [NOW_W-1:0]  now_ms;
    logic [NEED_W-1:0] need;

    modport source (output valid, output now_ms, output need, input ready);
    modport sink   (input valid, input now_ms, input need, output ready);
endinterface

interface tbrl_rsp_if;
    import tbrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                granted;
    logic [WAIT_W-1:0]   wait_us;
    logic [TOKOUT_W-1:0] tokens_left;

    modport source (output valid, output granted, output wait_us, output tokens_left,
                    input ready);
    modport sink   (input valid, input granted, input wait_us, input tokens_left,
                    output ready);
endinterface

[rtl/core/tbrl_serial_unit.sv]
// Shared shift-add / shift-subtract unit: saturating multiply and restoring divide.
module tbrl_serial_unit #(
    parameter int AW = 34
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbrl_pkg::tbrl_cmd_t           cmd,
    input  logic [AW-1:0]                 mul_x,
    input  logic [AW-1:0]                 mul_limit,
    input  logic [tbrl_pkg::RATE_W-1:0]   rate,
    input  logic [tbrl_pkg::NUM_W-1:0]    dividend,
    output tbrl_pkg::tbrl_sts_t           sts,
    output logic [AW-1:0]                 product,
    output logic [tbrl_pkg::NUM_W-1:0]    quotient
);
    import tbrl_pkg::*;

    // operands must hold steady while busy; dividend is sampled at start
    tbrl_op_t          op_reg, op_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [NUM_W-1:0]  sh_reg, sh_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic              bit_in;
    logic              sub;
    logic [AW-1:0]     a_op;
    logic [AW-1:0]     b_op;
    logic [AW:0]       sum;

    always_comb
    begin
        bit_in = sh_reg[NUM_W-1];
        sub    = (op_reg == OP_DIV);
        if (sub)
        begin
            a_op = {acc_reg[AW-2:0], bit_in};
            b_op = AW'(rate);
        end
        else
        begin
            a_op = {acc_reg[AW-2:0], 1'b0};
            b_op = bit_in ? mul_x : '0;
        end
        // for subtract, sum[AW] is the no-borrow flag
        sum = {1'b0, a_op} + {1'b0, b_op ^ {AW{sub}}} + (AW+1)'(sub);
    end

    always_comb
    begin
        op_next   = op_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            op_next   = cmd.op;
            acc_next  = '0;
            busy_next = 1'b1;
            if (cmd.op == OP_DIV)
            begin
                sh_next  = dividend;
                cnt_next = CNT_W'(NUM_W);
            end
            else
            begin
                sh_next  = {rate, {(NUM_W-RATE_W){1'b0}}};
                cnt_next = CNT_W'(RATE_W);
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                acc_next = sum[AW] ? sum[AW-1:0] : a_op;
                sh_next  = {sh_reg[NUM_W-2:0], sum[AW]};
            end
            else
            begin
                // clamp keeps the partial product at or below the limit
                acc_next = (sum[AW-1:0] > mul_limit) ? mul_limit : sum[AW-1:0];
                sh_next  = {sh_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
    end

    assign sts.done   = done_reg;
    assign sts.rem_nz = |acc_reg;
    assign product    = acc_reg;
    assign quotient   = sh_reg;

endmodule

[rtl/core/token_bucket_rate_limiter.sv]
// Top level of the token bucket rate limiter: sequencer, state and config port.
//
// Each request word (now_ms, need) first refills the bucket, unless it is
// exactly full: a bucket that was never refilled gets one fill_rate worth of
// tokens, otherwise elapsed_ms * fill_rate tokens (saturated at capacity),
// and the count is clamped to bucket_capacity. Covered requests consume
// their tokens and are granted; others report ceil(1000 * deficit /
// fill_rate) microseconds, or all ones when fill_rate is zero. One word is
// in flight at a time; req.ready is high only while the sequencer is idle,
// and a finished response sits in an output register so the next request
// can be taken before it is drained. The shared shift-add/subtract unit
// runs 20 multiply steps for the elapsed-time refill and 26 restoring-divide
// steps for the wait.
// Config (APB, pready tied high): fill_rate at 0x0, bucket_capacity at 0x4;
// paddr[1:0] are ignored. Write config only while idle.
module token_bucket_rate_limiter #(
    parameter int TOKEN_BITS = tbrl_pkg::TOKEN_BITS_DEF,
    parameter int TIME_BITS  = tbrl_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tbrl_req_if.sink                     req,
    tbrl_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbrl_pkg::ADDR_W-1:0]  paddr,
    input  logic [tbrl_pkg::DATA_W-1:0]  pwdata,
    output logic [tbrl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tbrl_pkg::*;

    // unit width: holds 2*cap + elapsed and the divide remainder
    localparam int MAXW = (TOKEN_BITS > TIME_BITS) ? TOKEN_BITS : TIME_BITS;
    localparam int AW   = ((MAXW > RATE_W) ? MAXW : RATE_W) + 2;

    // config registers
    logic [RATE_W-1:0]     fill_rate_reg;
    logic [CAP_W-1:0]      capacity_reg;
    logic                  cfg_wr;

    // sequencer and bucket state
    tbrl_state_t           state_reg, state_next;
    logic [TOKEN_BITS-1:0] token_reg, token_next;
    logic [TIME_BITS-1:0]  last_reg, last_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [NEED_W-1:0]     need_reg, need_next;
    logic [AW-1:0]         add_reg, add_next;
    logic [AW-1:0]         room_reg, room_next;
    logic                  granted_reg, granted_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_granted_reg, out_granted_next;
    logic [WAIT_W-1:0]     out_wait_reg, out_wait_next;
    logic [TOKOUT_W-1:0]   out_tok_reg, out_tok_next;

    // derived values
    logic [TOKEN_BITS-1:0] cap_t;
    logic [AW-1:0]         cap_aw;
    logic [TIME_BITS-1:0]  elapsed;
    logic [NEED_W-1:0]     deficit;
    logic [NUM_W-1:0]      num;
    logic                  in_acc;

    // shared unit
    tbrl_cmd_t             cmd;
    tbrl_sts_t             sts;
    logic [AW-1:0]         product;
    logic [NUM_W-1:0]      quotient;

    assign cap_t   = TOKEN_BITS'(capacity_reg);
    assign cap_aw  = AW'(cap_t);
    assign elapsed = now_reg - last_reg;        // wraps mod 2^TIME_BITS
    assign deficit = need_reg - token_reg[NEED_W-1:0];
    assign num     = NUM_W'(deficit) * NUM_W'(US_PER_MS);
    assign in_acc  = req.valid && req.ready;

    //------------------------------------------------------------------
    // APB config port
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_rate_reg <= FILL_RATE_RST;
            capacity_reg  <= CAPACITY_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FILL_RATE: fill_rate_reg <= pwdata[RATE_W-1:0];
                REG_CAPACITY:  capacity_reg  <= pwdata[CAP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FILL_RATE: prdata = DATA_W'(fill_rate_reg);
            REG_CAPACITY:  prdata = DATA_W'(capacity_reg);
            default:       prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // shared multiply / divide unit
    //------------------------------------------------------------------
    tbrl_serial_unit #(
        .AW (AW)
    ) u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mul_x     (AW'(elapsed)),
        .mul_limit (cap_aw),
        .rate      (fill_rate_reg),
        .dividend  (num),
        .sts       (sts),
        .product   (product),
        .quotient  (quotient)
    );

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        token_next       = token_reg;
        last_next        = last_reg;
        now_next         = now_reg;
        need_next        = need_reg;
        add_next         = add_reg;
        room_next        = room_reg;
        granted_next     = granted_reg;
        wait_next        = wait_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_wait_next    = out_wait_reg;
        out_tok_next     = out_tok_reg;
        cmd.start        = 1'b0;
        cmd.op           = OP_MUL;
        req.ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (in_acc)
                begin
                    now_next   = TIME_BITS'(req.now_ms);
                    need_next  = req.need;
                    state_next = ST_REFILL;
                end
            end

            ST_REFILL:
            begin
                // headroom is zero when the count sits at or above capacity
                room_next = (token_reg >= cap_t) ? '0 : AW'(cap_t - token_reg);
                if (token_reg == cap_t)
                begin
                    state_next = ST_SETTLE;         // full: no refill, time kept
                end
                else if (last_reg == '0)
                begin
                    // never refilled: one rate's worth, record the time
                    last_next  = now_reg;
                    add_next   = AW'(fill_rate_reg);
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (sts.done)
                begin
                    add_next = product;             // min(elapsed * rate, cap)
                    if (product != '0)
                    begin
                        last_next = now_reg;
                    end
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (add_reg >= room_reg)
                begin
                    token_next = cap_t;
                end
                else
                begin
                    token_next = token_reg + add_reg[TOKEN_BITS-1:0];
                end
                state_next = ST_SETTLE;
            end

            ST_SETTLE:
            begin
                if (token_reg >= TOKEN_BITS'(need_reg))
                begin
                    token_next   = token_reg - TOKEN_BITS'(need_reg);
                    granted_next = 1'b1;
                    wait_next    = '0;
                    state_next   = ST_DONE;
                end
                else if (fill_rate_reg == '0)
                begin
                    granted_next = 1'b0;
                    wait_next    = WAIT_MAX;
                    state_next   = ST_DONE;
                end
                else
                begin
                    granted_next = 1'b0;
                    cmd.start    = 1'b1;
                    cmd.op       = OP_DIV;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (sts.done)
                begin
                    // round up; quotient stays far below all ones
                    wait_next  = quotient + WAIT_W'(sts.rem_nz);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = granted_reg;
                    out_wait_next    = wait_reg;
                    out_tok_next     = TOKOUT_W'(token_reg);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            token_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            token_reg     <= token_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        need_reg        <= need_next;
        add_reg         <= add_next;
        room_reg        <= room_next;
        granted_reg     <= granted_next;
        wait_reg        <= wait_next;
        out_granted_reg <= out_granted_next;
        out_wait_reg    <= out_wait_next;
        out_tok_reg     <= out_tok_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.granted     = out_granted_reg;
    assign rsp.wait_us     = out_wait_reg;
    assign rsp.tokens_left = out_tok_reg;

endmodule

[rtl/core/tbrl_checker.sv]
// Port-level assertions for the token bucket rate limiter, bound to the top level.
module tbrl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          granted,
    input logic [tbrl_pkg::WAIT_W-1:0]   wait_us,
    input logic [tbrl_pkg::TOKOUT_W-1:0] tokens_left
);
    import tbrl_pkg::*;

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // a granted word carries no wait time
    a_grant_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> wait_us == '0)
        else $error("granted word with nonzero wait");

    // a refused word always asks to wait at least one microsecond
    a_refuse_waits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> wait_us != '0)
        else $error("refused word with zero wait");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted)
            && $stable(wait_us) && $stable(tokens_left))
        else $error("stalled response changed");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .granted     (rsp.granted),
    .wait_us     (rsp.wait_us),
    .tokens_left (rsp.tokens_left)
);

[tb/sv/tb_token_bucket_rate_limiter.sv]
// Self-checking testbench of the token bucket rate limiter: directed script, then random traffic.
module tb_token_bucket_rate_limiter;
    import tbrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 4;
    localparam int          RESET_CYCLES  = 9;
    // Room for roughly 800 words at their slowest, with receiver stalls and
    // sender idles, taken several times over.
    localparam int unsigned CYCLE_LIMIT   = 500_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 60;
    localparam int          RAND_PHASES   = 8;
    localparam int          PHASE_WORDS   = 94;
    localparam int          SCRIPT_LEN    = 26;

    // One verdict per request word.
    typedef struct packed {
        logic                granted;
        logic [WAIT_W-1:0]   wait_us;
        logic [TOKOUT_W-1:0] tokens_left;
    } verdict_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_e;

    // One line of the directed script. Request rows either carry a verdict
    // typed in by hand (typed = 1) or take the bucket model's verdict.
    typedef struct packed {
        row_kind_e         kind;
        logic              sel;
        logic [DATA_W-1:0] value;
        logic [NOW_W-1:0]  now_ms;
        logic [NEED_W-1:0] need;
        logic              typed;
        verdict_t          want;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tbrl_req_if req_ch ();
    tbrl_rsp_if rsp_ch ();

    token_bucket_rate_limiter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // Bucket model: its own copy of the registers and the bucket state.
    logic [RATE_W-1:0]   cfg_rate;
    logic [CAP_W-1:0]    cfg_cap;
    logic [TOKOUT_W-1:0] bucket_tokens;
    logic [NOW_W-1:0]    bucket_stamp;   // last refill time, 0 = never refilled

    verdict_t    verdicts [$];           // verdicts owed by the block, oldest first
    int unsigned error_count = 0;
    script_row_t script [SCRIPT_LEN];

    // Refill, then grant or work out the wait. Updates the bucket state.
    function automatic verdict_t admit_packet(input logic [NOW_W-1:0]  t,
                                              input logic [NEED_W-1:0] n);
        logic [NOW_W-1:0] span_ms;
        longint unsigned  add;
        longint unsigned  deficit;
        longint unsigned  num;
        longint unsigned  q;
        verdict_t         v;

        add = 0;
        v   = '0;
        // An exactly full bucket skips the refill and keeps its old stamp.
        if (bucket_tokens != cfg_cap) begin
            if (bucket_stamp == '0) begin
                // never refilled: one rate's worth; a stamp of zero stays "never"
                bucket_stamp = t;
                add          = cfg_rate;
            end else begin
                span_ms = t - bucket_stamp;    // wraps modulo 2^32
                if (cfg_rate == '0)
                    add = 0;
                else if (span_ms > cfg_cap / cfg_rate)
                    add = cfg_cap;             // product saturates
                else
                    add = span_ms * cfg_rate;
                if (add > cfg_cap)
                    add = cfg_cap;
                if (add != 0)
                    bucket_stamp = t;
            end
            // also clamps a count left above a lowered capacity
            if (bucket_tokens >= cfg_cap || add >= cfg_cap - bucket_tokens)
                bucket_tokens = cfg_cap;
            else
                bucket_tokens = TOKOUT_W'(bucket_tokens + add);
        end

        if (bucket_tokens >= n) begin
            bucket_tokens = bucket_tokens - n;
            v.granted     = 1'b1;
        end else begin
            deficit = n - bucket_tokens;
            num     = deficit * US_PER_MS;
            if (cfg_rate == '0) begin
                v.wait_us = WAIT_MAX;
            end else begin
                q = (num + cfg_rate - 1) / cfg_rate;   // round up
                if (q > WAIT_MAX)
                    q = WAIT_MAX;
                v.wait_us = q[WAIT_W-1:0];
            end
        end
        v.tokens_left = bucket_tokens;
        return v;
    endfunction

    function automatic script_row_t req_row(input logic [NOW_W-1:0]    t,
                                            input logic [NEED_W-1:0]   n,
                                            input logic                typed,
                                            input logic                g,
                                            input logic [WAIT_W-1:0]   w,
                                            input logic [TOKOUT_W-1:0] tok);
        script_row_t r;
        r        = '0;
        r.kind   = ROW_REQ;
        r.now_ms = t;
        r.need   = n;
        r.typed  = typed;
        r.want   = '{granted: g, wait_us: w, tokens_left: tok};
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic sel, input logic [DATA_W-1:0] value);
        script_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.sel   = sel;
        r.value = value;
        return r;
    endfunction

    // APB write: setup cycle, access cycle, register taken at the edge with pready.
    // Called at a rising edge; returns at the edge after the one at which the write
    // took effect, so writes can follow each other directly.
    task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_FILL_RATE)
            cfg_rate = value[RATE_W-1:0];
        else
            cfg_cap = value[CAP_W-1:0];
        @(posedge clk);
    endtask

    // Present one request word and hold it until taken. Valid stays high on
    // return so the next word can follow back to back.
    task automatic offer(input logic [NOW_W-1:0]  t,
                         input logic [NEED_W-1:0] n,
                         input logic              typed,
                         input verdict_t          want);
        verdict_t v;
        req_ch.valid  <= 1'b1;
        req_ch.now_ms <= t;
        req_ch.need   <= n;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        v = admit_packet(t, n);
        verdicts.push_back(typed ? want : v);
    endtask

    // Drop valid and put noise on the payload for a gap set by the argument.
    task automatic idle_for(input int unsigned cycles);
        req_ch.valid  <= 1'b0;
        req_ch.now_ms <= $urandom;
        req_ch.need   <= NEED_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every verdict is back and the sequencer is idle.
    task automatic settle();
        idle_for(1);
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Response check: each word taken off rsp against the oldest verdict.
    always @(posedge clk) begin : verdict_check
        verdict_t exp_v;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (verdicts.size() == 0) begin
                $error("unexpected response word: granted %0d wait_us %0d tokens_left %0d",
                       rsp_ch.granted, rsp_ch.wait_us, rsp_ch.tokens_left);
                error_count++;
            end else begin
                exp_v = verdicts.pop_front();
                if (rsp_ch.granted !== exp_v.granted) begin
                    $error("granted: expected %0d, got %0d", exp_v.granted, rsp_ch.granted);
                    error_count++;
                end
                if (rsp_ch.wait_us !== exp_v.wait_us) begin
                    $error("wait_us: expected %0d, got %0d", exp_v.wait_us, rsp_ch.wait_us);
                    error_count++;
                end
                if (rsp_ch.tokens_left !== exp_v.tokens_left) begin
                    $error("tokens_left: expected %0d, got %0d",
                           exp_v.tokens_left, rsp_ch.tokens_left);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure: a 16-bit ready pattern rotated every cycle and
    // swapped for a new one after a random span. A set bit is forced into
    // the sparse patterns so no pattern stalls forever.
    initial begin : rsp_stall
        logic [15:0] pat;
        int unsigned span;
        pat          = 16'hFFFF;
        span         = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (span == 0) begin
                span = $urandom_range(300, 40);
                case ($urandom_range(3))
                    0:       pat = 16'hFFFF;                       // no stalls
                    1:       pat = 16'($urandom) | 16'h0001;
                    2:       pat = 16'h0001;                       // longest stall
                    default: pat = 16'($urandom | $urandom) | 16'h8000;
                endcase
            end
            span--;
            rsp_ch.ready <= pat[0];
            pat = {pat[0], pat[15:1]};
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [NOW_W-1:0]  wall_ms;
        logic [NEED_W-1:0] need;
        logic [RATE_W-1:0] rate_pick;
        logic [CAP_W-1:0]  cap_pick;
        int unsigned       burst_left;
        int unsigned       lim;
        int unsigned       pick;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.now_ms = '0;
        req_ch.need   = '0;

        cfg_rate      = FILL_RATE_RST;
        cfg_cap       = CAPACITY_RST;
        bucket_tokens = '0;
        bucket_stamp  = '0;

        // Directed script. Reset state: rate 1250, capacity 1250000, empty
        // bucket, never refilled.
        script = '{
            // refill at time zero: +1250, stamp stays zero; zero need
            req_row(32'd0,          16'd0,     1'b1, 1'b1, 26'd0, 32'd1250),
            // still "never refilled", so another +1250; big refusal
            req_row(32'd0,          16'd65535, 1'b0, 1'b0, '0, '0),
            req_row(32'd100,        16'd1000,  1'b0, 1'b0, '0, '0),
            req_row(32'd100,        16'd3000,  1'b0, 1'b0, '0, '0),
            req_row(32'd101,        16'd1,     1'b0, 1'b0, '0, '0),
            // deficit of one token: wait rounds up
            req_row(32'd101,        16'd4000,  1'b0, 1'b0, '0, '0),
            // elapsed * rate saturates: bucket full
            req_row(32'd1000101,    16'd0,     1'b1, 1'b1, 26'd0, 32'd1250000),
            // full bucket skips refill even with time running backwards
            req_row(32'd5,          16'd0,     1'b1, 1'b1, 26'd0, 32'd1250000),
            // capacity lowered below the count: clamped on next request
            cfg_row(REG_CAPACITY,   32'd1000),
            req_row(32'd1000101,    16'd0,     1'b1, 1'b1, 26'd0, 32'd1000),
            req_row(32'd1000101,    16'd500,   1'b0, 1'b0, '0, '0),
            cfg_row(REG_CAPACITY,   32'd100000),
            req_row(32'hFFFF_FFFE,  16'd0,     1'b1, 1'b1, 26'd0, 32'd100000),
            req_row(32'hFFFF_FFFE,  16'd65535, 1'b0, 1'b0, '0, '0),
            // time wraps: 3 ms elapsed
            req_row(32'd1,          16'd0,     1'b0, 1'b0, '0, '0),
            // zero fill rate: nothing added, wait pinned at all ones
            cfg_row(REG_FILL_RATE,  32'd0),
            req_row(32'd50,         16'd65535, 1'b1, 1'b0, WAIT_MAX, 32'd38215),
            cfg_row(REG_FILL_RATE,  32'h000F_FFFF),
            req_row(32'd51,         16'd0,     1'b1, 1'b1, 26'd0, 32'd100000),
            // zero capacity: count drops to 0, any nonzero need refused
            cfg_row(REG_CAPACITY,   32'd0),
            req_row(32'd51,         16'd0,     1'b1, 1'b1, 26'd0, 32'd0),
            req_row(32'd60,         16'd1,     1'b1, 1'b0, 26'd1, 32'd0),
            // largest capacity, slowest rate: waits near the top of range
            cfg_row(REG_CAPACITY,   32'hFFFF_FFFF),
            cfg_row(REG_FILL_RATE,  32'd1),
            req_row(32'd60,         16'd65535, 1'b0, 1'b0, '0, '0),
            req_row(32'd61,         16'd65535, 1'b0, 1'b0, '0, '0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_reg(script[i].sel, script[i].value);
            end else begin
                offer(script[i].now_ms, script[i].need, script[i].typed, script[i].want);
            end
        end

        // Random part: one register setting per phase, the extremes among them.
        wall_ms    = 32'd200;
        burst_left = $urandom_range(1, 10);
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    rate_pick = FILL_RATE_RST;
                    cap_pick  = CAPACITY_RST;
                end
                1: begin
                    rate_pick = RATE_W'($urandom_range(2000, 1));
                    cap_pick  = $urandom_range(200000, 1000);
                end
                2: begin   // slow refill: many refusals and rounded waits
                    rate_pick = RATE_W'($urandom_range(50, 1));
                    cap_pick  = $urandom_range(70000, 1);
                end
                3: begin
                    rate_pick = {RATE_W{1'b1}};
                    cap_pick  = {CAP_W{1'b1}};
                end
                4: begin   // zero or unit rate
                    rate_pick = RATE_W'($urandom_range(1, 0));
                    cap_pick  = $urandom_range(5000, 1);
                end
                5: begin
                    rate_pick = RATE_W'($urandom_range(5000, 1));
                    cap_pick  = '0;
                end
                6: begin
                    rate_pick = RATE_W'($urandom);
                    cap_pick  = $urandom;
                end
                default: begin   // small bucket: often exactly full
                    rate_pick = RATE_W'($urandom_range(2000, 1));
                    cap_pick  = $urandom_range(3000, 1);
                end
            endcase
            // upper data bits of the rate register are don't-care
            write_reg(REG_FILL_RATE, {12'($urandom), rate_pick});
            write_reg(REG_CAPACITY, cap_pick);

            case ($urandom_range(3))
                0:       wall_ms = 32'hFFFF_FFFF - $urandom_range(50, 0);   // near wrap
                1:       wall_ms = $urandom;
                default: ;
            endcase

            for (int k = 0; k < PHASE_WORDS; k++) begin
                // time moves on most often by a few ms, sometimes stays, jumps or goes to zero
                pick = $urandom_range(99);
                if (pick < 45)
                    wall_ms = wall_ms + $urandom_range(3, 1);
                else if (pick < 60)
                    ;
                else if (pick < 80)
                    wall_ms = wall_ms + $urandom_range(100, 0);
                else if (pick < 90)
                    wall_ms = wall_ms + $urandom_range(100000, 0);
                else if (pick < 95)
                    wall_ms = wall_ms + $urandom;
                else
                    wall_ms = '0;

                lim  = (cfg_cap > 32'd65535) ? 65535 : cfg_cap;
                pick = $urandom_range(99);
                if (pick < 40)
                    need = NEED_W'($urandom_range(1500, 0));
                else if (pick < 60)
                    need = NEED_W'($urandom_range(lim, 0));
                else if (pick < 75)
                    need = NEED_W'($urandom);
                else if (pick < 82)
                    need = '0;
                else if (pick < 89)
                    need = {NEED_W{1'b1}};
                else
                    need = NEED_W'($urandom_range((cfg_rate > 20'd65535) ? 65535 : cfg_rate,
                                                  0));

                offer(wall_ms, need, 1'b0, '0);

                // sender bursts: short or long runs, then a gap or a full drain
                if (burst_left == 0) begin
                    if ($urandom_range(15) == 0)
                        settle();
                    else
                        idle_for($urandom_range(20, 1));
                    burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30)
                                                          : $urandom_range(10, 1);
                end else begin
                    burst_left--;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
